// ===== rtl/edad_pkg.sv =====
// Shared types and constants for the echo distance averaging display block.
// Holds the sequencer state type, register indexes, field widths and the
// seven-segment decoder. Depends on nothing.
package edad_pkg;

	localparam int TICKS_W     = 16;
	localparam int DIVISOR_W   = 8;
	localparam int CM_W        = 14;
	localparam int SEG_W       = 7;
	localparam int DIGIT_W     = 4;
	localparam int NUM_DIGITS  = 4;

	localparam logic [DIVISOR_W-1:0] TICKS_PER_CM_RESET = 8'd117;
	localparam logic [CM_W-1:0]      MAX_RANGE_RESET    = 14'd400;
	localparam logic [CM_W-1:0]      DISPLAY_LIMIT      = 14'd9999;

	// configuration register indexes
	localparam logic REG_TICKS_PER_CM = 1'b0;
	localparam logic REG_MAX_RANGE_CM = 1'b1;

	// segment codes, bit order gfedcba
	localparam logic [SEG_W-1:0] SEG_0     = 7'h3F;
	localparam logic [SEG_W-1:0] SEG_1     = 7'h06;
	localparam logic [SEG_W-1:0] SEG_2     = 7'h5B;
	localparam logic [SEG_W-1:0] SEG_3     = 7'h4F;
	localparam logic [SEG_W-1:0] SEG_4     = 7'h66;
	localparam logic [SEG_W-1:0] SEG_5     = 7'h6D;
	localparam logic [SEG_W-1:0] SEG_6     = 7'h7D;
	localparam logic [SEG_W-1:0] SEG_7     = 7'h07;
	localparam logic [SEG_W-1:0] SEG_8     = 7'h7F;
	localparam logic [SEG_W-1:0] SEG_9     = 7'h6F;
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_CM,
		S_RANGE,
		S_SUM,
		S_DIV_MEAN,
		S_BCD,
		S_OUT
	} state_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] code;
		unique case (digit)
			4'd0:    code = SEG_0;
			4'd1:    code = SEG_1;
			4'd2:    code = SEG_2;
			4'd3:    code = SEG_3;
			4'd4:    code = SEG_4;
			4'd5:    code = SEG_5;
			4'd6:    code = SEG_6;
			4'd7:    code = SEG_7;
			4'd8:    code = SEG_8;
			4'd9:    code = SEG_9;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/echo_distance_average_display_core.sv =====
// Echo distance averaging core with a four-digit seven-segment readout.
// Depends on edad_pkg for widths, register indexes, state type and segment decoder.
//
// Usage:
//   Configuration: write cfg_data to register cfg_index while cfg_write is high
//   (0: ticks_per_cm, 1: max_range_cm). Write only while the block is idle.
//   Input: one echo width per transaction on in_valid/in_ready/echo_ticks.
//   Output: one transaction per input on out_valid/out_ready carrying the window
//   mean in filtered_cm and the segment codes of its four digits.
//   Timing: a single restoring divider of QUO_W steps (17 at the default depth)
//   serves both the tick-to-centimetre and the mean division, the window sum
//   reads one entry a cycle, and a 14-step shift-add-3 splits the digits.
//   in_ready stays low while an item is in work.
//   Stall: the result waits in an output register; the next item is accepted and
//   processed, and its result is held back until the previous one is taken.
//   Reset: registers return to 117 and 400, the window is empty, no output valid.
module echo_distance_average_display_core
	import edad_pkg::*;
#(
	parameter int WINDOW_DEPTH = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [CM_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TICKS_W-1:0]   echo_ticks,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CM_W-1:0]      filtered_cm,
	output logic [SEG_W-1:0]     seg_thousands,
	output logic [SEG_W-1:0]     seg_hundreds,
	output logic [SEG_W-1:0]     seg_tens,
	output logic [SEG_W-1:0]     seg_ones
);

	localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W   = CM_W + COUNT_W;
	localparam int QUO_W   = (SUM_W > TICKS_W) ? SUM_W : TICKS_W;
	localparam int STEP_W  = $clog2(QUO_W + 1);
	localparam int BCD_W   = DIGIT_W * NUM_DIGITS;

	localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(WINDOW_DEPTH);
	localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(QUO_W - 1);
	localparam logic [STEP_W-1:0]  BCD_LAST    = STEP_W'(CM_W - 1);

	state_t state_q, state_d;

	logic [DIVISOR_W-1:0] ticks_per_cm_q;
	logic [CM_W-1:0]      max_range_q;

	logic [SLOT_W-1:0]    slot_q;
	logic                 full_q;
	logic [COUNT_W-1:0]   count_q;
	logic [STEP_W-1:0]    cnt_q;
	logic                 rd_vld_q;
	logic                 out_valid_q;

	logic [CM_W-1:0]      window_mem [WINDOW_DEPTH];
	logic [CM_W-1:0]      rd_data_q;
	logic [SUM_W-1:0]     acc_q;

	logic [QUO_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CM_W-1:0]      mean_q;
	logic [CM_W-1:0]      bin_q;
	logic [BCD_W-1:0]     bcd_q;

	logic [CM_W-1:0]      filtered_q;
	logic [SEG_W-1:0]     seg_th_q, seg_hu_q, seg_te_q, seg_on_q;

	// sequencer outputs
	logic in_take, div_step, range_step, sum_read, sum_done, bcd_step, out_load;

	// shared divider step
	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W+1:0] diff;
	logic                 fits;

	// range clamp
	logic [CM_W-1:0]      limit;
	logic [CM_W-1:0]      cm_val;

	// window bookkeeping after the write
	logic                 wrap;
	logic [SLOT_W-1:0]    slot_next;
	logic [COUNT_W-1:0]   count_next;

	logic                 sum_more;
	logic [BCD_W-1:0]     bcd_adj;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DIV_CM;
			S_DIV_CM:   if (cnt_q == DIV_LAST) state_d = S_RANGE;
			S_RANGE:    state_d = S_SUM;
			S_SUM:      if (!sum_more && !rd_vld_q) state_d = S_DIV_MEAN;
			S_DIV_MEAN: if (cnt_q == DIV_LAST) state_d = S_BCD;
			S_BCD:      if (cnt_q == BCD_LAST) state_d = S_OUT;
			S_OUT:      if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		in_take    = 1'b0;
		div_step   = 1'b0;
		range_step = 1'b0;
		sum_read   = 1'b0;
		sum_done   = 1'b0;
		bcd_step   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				in_take  = in_valid;
			end
			S_DIV_CM:   div_step   = 1'b1;
			S_RANGE:    range_step = 1'b1;
			S_SUM: begin
				sum_read = sum_more;
				sum_done = !sum_more && !rd_vld_q;
			end
			S_DIV_MEAN: div_step = 1'b1;
			S_BCD:      bcd_step = 1'b1;
			S_OUT:      out_load = !out_valid_q || out_ready;
			default:    in_ready = 1'b0;
		endcase
	end

	// ---------------- datapath logic ----------------
	// a zero divisor never borrows, so the quotient saturates and the range
	// check below turns it into zero; a zero echo divides to zero anyway
	assign rem_sh = {rem_q, quo_q[QUO_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = !diff[DIVISOR_W+1];

	assign limit  = (max_range_q < DISPLAY_LIMIT) ? max_range_q : DISPLAY_LIMIT;
	assign cm_val = (quo_q > QUO_W'(limit)) ? '0 : quo_q[CM_W-1:0];

	assign wrap       = (slot_q == SLOT_LAST);
	assign slot_next  = wrap ? '0 : slot_q + SLOT_W'(1);
	assign count_next = (wrap || full_q) ? COUNT_FULL : COUNT_W'(slot_q) + COUNT_W'(1);

	assign sum_more = (cnt_q < STEP_W'(count_q));

	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			bcd_adj[d*DIGIT_W +: DIGIT_W] = (bcd_q[d*DIGIT_W +: DIGIT_W] >= 4'd5)
				? bcd_q[d*DIGIT_W +: DIGIT_W] + 4'd3
				: bcd_q[d*DIGIT_W +: DIGIT_W];
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ticks_per_cm_q <= TICKS_PER_CM_RESET;
			max_range_q    <= MAX_RANGE_RESET;
			slot_q         <= '0;
			full_q         <= 1'b0;
			count_q        <= '0;
			cnt_q          <= '0;
			rd_vld_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_TICKS_PER_CM: ticks_per_cm_q <= cfg_data[DIVISOR_W-1:0];
					REG_MAX_RANGE_CM: max_range_q    <= cfg_data;
					default:          max_range_q    <= max_range_q;
				endcase
			end
			if (range_step) begin
				slot_q  <= slot_next;
				full_q  <= full_q | wrap;
				count_q <= count_next;
			end
			// step counter: divider steps, read index, digit shifts
			if (in_take || range_step || sum_done || state_d != state_q) begin
				cnt_q <= '0;
			end else if (div_step || sum_read || bcd_step) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
			rd_vld_q <= sum_read;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (range_step) begin
			window_mem[slot_q] <= cm_val;
		end
		if (sum_read) begin
			rd_data_q <= window_mem[cnt_q[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			quo_q <= QUO_W'(echo_ticks);
			rem_q <= '0;
			dvs_q <= ticks_per_cm_q;
		end else if (div_step) begin
			quo_q <= {quo_q[QUO_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end else if (sum_done) begin
			quo_q <= QUO_W'(acc_q);
			rem_q <= '0;
			dvs_q <= DIVISOR_W'(count_q);
		end

		if (range_step) begin
			acc_q <= '0;
		end else if (rd_vld_q) begin
			acc_q <= acc_q + SUM_W'(rd_data_q);
		end

		// hand the mean to the digit split when the divider finishes
		if (state_q == S_DIV_MEAN && state_d == S_BCD) begin
			mean_q <= quo_q[CM_W-2:0] == '0 && !quo_q[CM_W-1] && fits
				? CM_W'(1) : {quo_q[CM_W-2:0], fits};
			bin_q  <= {quo_q[CM_W-2:0], fits};
			bcd_q  <= '0;
		end else if (bcd_step) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
		end

		if (out_load) begin
			filtered_q <= mean_q;
			seg_th_q   <= (bcd_q[15:12] == 4'd0) ? SEG_BLANK : seg_of(bcd_q[15:12]);
			seg_hu_q   <= (bcd_q[15:8] == 8'd0) ? SEG_BLANK : seg_of(bcd_q[11:8]);
			seg_te_q   <= (bcd_q[15:4] == 12'd0) ? SEG_BLANK : seg_of(bcd_q[7:4]);
			seg_on_q   <= seg_of(bcd_q[3:0]);
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered_cm   = filtered_q;
	assign seg_thousands = seg_th_q;
	assign seg_hundreds  = seg_hu_q;
	assign seg_tens      = seg_te_q;
	assign seg_ones      = seg_on_q;

endmodule

// ===== tb/edad_checker.sv =====
// Scoreboard for the echo distance averaging display core: tracks register writes,
// predicts each readout from accepted echo widths and compares the output side.
// Depends on edad_pkg for widths, register indexes and segment codes.
module edad_checker
	import edad_pkg::*;
#(
	parameter int WINDOW_DEPTH = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [CM_W-1:0]    cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [TICKS_W-1:0] echo_ticks,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CM_W-1:0]    filtered_cm,
	input  logic [SEG_W-1:0]   seg_thousands,
	input  logic [SEG_W-1:0]   seg_hundreds,
	input  logic [SEG_W-1:0]   seg_tens,
	input  logic [SEG_W-1:0]   seg_ones,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CM_W-1:0]  cm;
		logic [SEG_W-1:0] thousands;
		logic [SEG_W-1:0] hundreds;
		logic [SEG_W-1:0] tens;
		logic [SEG_W-1:0] ones;
	} readout_t;

	localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
		SEG_0, SEG_1, SEG_2, SEG_3, SEG_4, SEG_5, SEG_6, SEG_7, SEG_8, SEG_9
	};

	logic [DIVISOR_W-1:0] divisor;
	logic [CM_W-1:0]      range_cm;
	logic [CM_W-1:0]      window_cm [WINDOW_DEPTH];
	int                   next_slot;
	bit                   wrapped;
	readout_t             expected_readouts [$];
	readout_t             want;
	readout_t             got;

	// Convert, push into the ring and average the filled part of the window.
	function automatic readout_t predict_readout(input logic [TICKS_W-1:0] ticks);
		int unsigned limit;
		int unsigned cm;
		int unsigned sum;
		int unsigned count;
		int unsigned mean;
		readout_t r;
		limit = (range_cm < DISPLAY_LIMIT) ? range_cm : DISPLAY_LIMIT;
		if (ticks == 0 || divisor == 0)
			cm = 0;
		else
			cm = ticks / divisor;
		if (cm > limit)
			cm = 0;
		window_cm[next_slot] = cm[CM_W-1:0];
		next_slot++;
		if (next_slot == WINDOW_DEPTH) begin
			next_slot = 0;
			wrapped = 1'b1;
		end
		count = wrapped ? WINDOW_DEPTH : next_slot;
		sum = 0;
		for (int i = 0; i < count; i++)
			sum += window_cm[i];
		mean = sum / count;
		r.cm        = mean[CM_W-1:0];
		r.thousands = (mean >= 1000) ? DIGIT_SEG[(mean / 1000) % 10] : SEG_BLANK;
		r.hundreds  = (mean >= 100) ? DIGIT_SEG[(mean / 100) % 10] : SEG_BLANK;
		r.tens      = (mean >= 10) ? DIGIT_SEG[(mean / 10) % 10] : SEG_BLANK;
		r.ones      = DIGIT_SEG[mean % 10];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor   = TICKS_PER_CM_RESET;
			range_cm  = MAX_RANGE_RESET;
			next_slot = 0;
			wrapped   = 1'b0;
			errors    = 0;
			checked   = 0;
			pending   = 0;
			expected_readouts.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_TICKS_PER_CM)
					divisor = cfg_data[DIVISOR_W-1:0];
				else
					range_cm = cfg_data;
			end
			if (in_valid && in_ready)
				expected_readouts.push_back(predict_readout(echo_ticks));
			if (out_valid && out_ready) begin
				got = '{filtered_cm, seg_thousands, seg_hundreds, seg_tens, seg_ones};
				if (expected_readouts.size() == 0) begin
					$error("unexpected readout transaction: filtered_cm %0d", filtered_cm);
					errors++;
				end else begin
					want = expected_readouts.pop_front();
					checked++;
					if (got.cm !== want.cm) begin
						$error("filtered_cm: expected %0d, got %0d", want.cm, got.cm);
						errors++;
					end
					if (got.thousands !== want.thousands) begin
						$error("seg_thousands: expected %h, got %h", want.thousands,
							got.thousands);
						errors++;
					end
					if (got.hundreds !== want.hundreds) begin
						$error("seg_hundreds: expected %h, got %h", want.hundreds,
							got.hundreds);
						errors++;
					end
					if (got.tens !== want.tens) begin
						$error("seg_tens: expected %h, got %h", want.tens, got.tens);
						errors++;
					end
					if (got.ones !== want.ones) begin
						$error("seg_ones: expected %h, got %h", want.ones, got.ones);
						errors++;
					end
				end
			end
			pending = expected_readouts.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the echo distance averaging display testbench: clock, reset, echo and
// register stimulus, output back-pressure and the final verdict.
// Depends on edad_pkg, echo_distance_average_display_core and edad_checker.
module tb
	import edad_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 5;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 150;
	localparam int PHASES       = 9;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [CM_W-1:0]    cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [TICKS_W-1:0] echo_ticks;
	logic               out_valid;
	logic               out_ready;
	logic [CM_W-1:0]    filtered_cm;
	logic [SEG_W-1:0]   seg_thousands;
	logic [SEG_W-1:0]   seg_hundreds;
	logic [SEG_W-1:0]   seg_tens;
	logic [SEG_W-1:0]   seg_ones;

	int errors;
	int pending;
	int checked;
	int cycles;
	int echoes_sent;
	int settings_used;
	int cur_divisor;
	int cur_range;
	bit no_gaps;

	echo_distance_average_display_core #(.WINDOW_DEPTH(DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.echo_ticks   (echo_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.filtered_cm  (filtered_cm),
		.seg_thousands(seg_thousands),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_ones     (seg_ones)
	);

	edad_checker #(.WINDOW_DEPTH(DEPTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.echo_ticks   (echo_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.filtered_cm  (filtered_cm),
		.seg_thousands(seg_thousands),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_ones     (seg_ones),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d readouts outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 7);
	endfunction

	// Readout side: random stall before each transaction.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Hold valid and payload until the transaction goes through.
	task automatic send_echo(input logic [TICKS_W-1:0] ticks);
		int gap;
		@(negedge clk);
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		echo_ticks <= ticks;
		do @(posedge clk); while (!in_ready);
		echoes_sent++;
	endtask

	// Drop valid and let every outstanding readout drain.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CM_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_TICKS_PER_CM)
			cur_divisor = int'(data[DIVISOR_W-1:0]);
		else
			cur_range = int'(data);
	endtask

	// Upper data bits above the divisor width are junk and must be ignored.
	task automatic apply_setting(input int divisor, input int range_cm);
		logic [CM_W-1:0] junk;
		drain();
		junk = CM_W'($urandom_range(0, (1 << CM_W) - 1));
		write_reg(REG_TICKS_PER_CM, {junk[CM_W-1:DIVISOR_W], divisor[DIVISOR_W-1:0]});
		write_reg(REG_MAX_RANGE_CM, range_cm[CM_W-1:0]);
		settings_used++;
	endtask

	// Mix of no-echo, raw, in-range and limit-edge widths for the active setting.
	function automatic logic [TICKS_W-1:0] pick_echo();
		int limit;
		longint t;
		limit = (cur_range < DISPLAY_LIMIT) ? cur_range : DISPLAY_LIMIT;
		if (cur_divisor == 0)
			return TICKS_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			0:       t = 0;
			1, 2:    t = $urandom_range(0, 65535);
			3:       t = longint'(limit + 1) * cur_divisor + $urandom_range(0, cur_divisor - 1);
			4:       t = longint'(limit) * cur_divisor + $urandom_range(0, cur_divisor - 1);
			default: t = longint'($urandom_range(0, limit)) * cur_divisor
				+ $urandom_range(0, cur_divisor - 1);
		endcase
		if (t > 65535)
			t = $urandom_range(0, 65535);
		return t[TICKS_W-1:0];
	endfunction

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_TICKS_PER_CM;
		cfg_data      = '0;
		in_valid      = 1'b0;
		echo_ticks    = '0;
		no_gaps       = 1'b0;
		cycles        = 0;
		echoes_sent   = 0;
		settings_used = 1;
		cur_divisor   = TICKS_PER_CM_RESET;
		cur_range     = MAX_RANGE_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: no echo, rounding down, exact limit and just past it
		send_echo(16'd0);
		send_echo(16'd116);
		send_echo(16'd117);
		send_echo(16'd1170);
		send_echo(16'd11700);
		send_echo(16'd46800);
		send_echo(16'd46917);
		send_echo(16'hFFFF);

		// full display range: four digits, then blanking at each boundary
		apply_setting(1, 9999);
		repeat (DEPTH) send_echo(16'd9999);
		send_echo(16'd10000);
		send_echo(16'd1000);
		send_echo(16'd999);
		send_echo(16'd100);
		send_echo(16'd99);
		send_echo(16'd10);
		send_echo(16'd9);

		// zero divisor
		apply_setting(0, 400);
		send_echo(16'hFFFF);
		send_echo(16'd1);

		// zero range
		apply_setting(1, 0);
		send_echo(16'd0);
		send_echo(16'd5);

		// limit above the display range is clipped
		apply_setting(1, (1 << CM_W) - 1);
		send_echo(16'd16383);
		send_echo(16'd9999);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       apply_setting(TICKS_PER_CM_RESET, MAX_RANGE_RESET);
				1:       apply_setting(1, 9999);
				2:       apply_setting(255, (1 << CM_W) - 1);
				3:       apply_setting(0, $urandom_range(1, 9999));
				4:       apply_setting($urandom_range(1, 255), 0);
				5:       apply_setting(1, (1 << CM_W) - 1);
				default: apply_setting($urandom_range(1, 255), $urandom_range(1, (1 << CM_W) - 1));
			endcase
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				if (i % 40 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				send_echo(pick_echo());
			end
			no_gaps = 1'b0;
		end

		drain();
		$display("Covered %0d echo readings under %0d register settings, %0d readouts compared.",
			echoes_sent, settings_used, checked);
		$display("Settings included zero divisor, zero range and limits past the display range.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/edad_pkg.sv
rtl/echo_distance_average_display_core.sv
tb/edad_checker.sv
tb/tb.sv
